FILE: hdl/fdrdwt_pkg.sv
// Shared types and constants for the frequency-domain redundant wavelet block.
// Used by fdrdwt_ctrl, fdrdwt_dp, the top level and its checker.
package fdrdwt_pkg;

  localparam int LEN_W     = 11;  // signal_length register
  localparam int LEV_W     = 4;   // levels register
  localparam int BIN_W     = 10;
  localparam int SMP_W     = 16;
  localparam int OUT_W     = 24;
  localparam int LVL_OUT_W = 3;
  localparam int PROD_W    = SMP_W + OUT_W;
  localparam int FRAC_W    = 14;  // Q2.14 filter taps
  localparam int CNT_W     = 4;
  localparam int MOD_STEPS = BIN_W;  // one remainder bit per cycle
  localparam int MUL_TERMS = 8;      // partial products per level
  localparam int TERM_W    = 3;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS        = 1'b1;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_SAMPLE  = 1'b1;
  localparam logic KIND_DETAIL  = 1'b0;
  localparam logic KIND_APPROX  = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [BIN_W-1:0]        bin_index;
    logic signed [SMP_W-1:0] first_real;
    logic signed [SMP_W-1:0] first_imag;
    logic signed [SMP_W-1:0] second_real;
    logic signed [SMP_W-1:0] second_imag;
  } in_item_t;

  typedef struct packed {
    logic                    kind;
    logic [LVL_OUT_W-1:0]    level_number;
    logic [BIN_W-1:0]        out_index;
    logic signed [OUT_W-1:0] out_real;
    logic signed [OUT_W-1:0] out_imag;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] low_re;
    logic signed [SMP_W-1:0] low_im;
    logic signed [SMP_W-1:0] high_re;
    logic signed [SMP_W-1:0] high_im;
  } filt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_MUL,
    ST_EMIT_D,
    ST_EMIT_A
  } state_t;

  typedef struct packed {
    logic              load_item;
    logic              mem_write;
    logic              mod_step;
    logic              mem_read;
    logic              mul_en;
    logic [TERM_W-1:0] mul_term;
    logic              acc_en;
    logic [TERM_W-1:0] acc_term;
    logic              emit_detail;
    logic              emit_approx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sample_item;
    logic last_level;
    logic out_free;
  } ctrl_status_t;

endpackage

FILE: hdl/fdrdwt_ctrl.sv
// Sequencer for the wavelet block: bin reduction, per-level multiply steps, emits.
// Depends on fdrdwt_pkg.
module fdrdwt_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  fdrdwt_pkg::ctrl_status_t status,
  output fdrdwt_pkg::ctrl_cmd_t    cmd
);

  fdrdwt_pkg::state_t state, state_next;
  logic [fdrdwt_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [fdrdwt_pkg::CNT_W-1:0] cnt_dec;

  assign cnt_dec = cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fdrdwt_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      fdrdwt_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (in_valid && status.sample_item) state_next = fdrdwt_pkg::ST_MOD;
      end
      fdrdwt_pkg::ST_MOD: begin
        cnt_next = cnt + 1'b1;
        if (cnt == fdrdwt_pkg::CNT_W'(fdrdwt_pkg::MOD_STEPS - 1)) begin
          state_next = fdrdwt_pkg::ST_READ;
        end
      end
      fdrdwt_pkg::ST_READ: begin
        cnt_next   = '0;
        state_next = fdrdwt_pkg::ST_MUL;
      end
      fdrdwt_pkg::ST_MUL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == fdrdwt_pkg::CNT_W'(fdrdwt_pkg::MUL_TERMS)) begin
          state_next = fdrdwt_pkg::ST_EMIT_D;
        end
      end
      fdrdwt_pkg::ST_EMIT_D: begin
        if (status.out_free) begin
          state_next = status.last_level ? fdrdwt_pkg::ST_EMIT_A : fdrdwt_pkg::ST_READ;
        end
      end
      fdrdwt_pkg::ST_EMIT_A: begin
        if (status.out_free) state_next = fdrdwt_pkg::ST_IDLE;
      end
      default: state_next = fdrdwt_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      fdrdwt_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid && status.sample_item;
        cmd.mem_write = in_valid && !status.sample_item;
      end
      fdrdwt_pkg::ST_MOD:  cmd.mod_step = 1'b1;
      fdrdwt_pkg::ST_READ: cmd.mem_read = 1'b1;
      fdrdwt_pkg::ST_MUL: begin
        // product of term cnt is formed while term cnt-1 is summed
        cmd.mul_en   = (cnt < fdrdwt_pkg::CNT_W'(fdrdwt_pkg::MUL_TERMS));
        cmd.mul_term = cnt[fdrdwt_pkg::TERM_W-1:0];
        cmd.acc_en   = (cnt != '0);
        cmd.acc_term = cnt_dec[fdrdwt_pkg::TERM_W-1:0];
      end
      fdrdwt_pkg::ST_EMIT_D: cmd.emit_detail = status.out_free;
      fdrdwt_pkg::ST_EMIT_A: cmd.emit_approx = status.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule

FILE: hdl/fdrdwt_dp.sv
// Datapath: config registers, filter memory, bin remainder unit, shared
// multiplier with accumulate/round/saturate, and the output register.
// Depends on fdrdwt_pkg.
module fdrdwt_dp #(
  parameter int MAX_LENGTH = 1024,
  parameter int MAX_LEVELS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [fdrdwt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fdrdwt_pkg::LEN_W-1:0]        cfg_data,
  input  fdrdwt_pkg::in_item_t                in_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output fdrdwt_pkg::out_item_t               out_data,
  input  fdrdwt_pkg::ctrl_cmd_t               cmd,
  output fdrdwt_pkg::ctrl_status_t            status
);

  localparam int LW = fdrdwt_pkg::LEN_W;
  localparam int VW = fdrdwt_pkg::LEV_W;
  localparam int OW = fdrdwt_pkg::OUT_W;
  localparam int SW = fdrdwt_pkg::SMP_W;
  localparam int PW = fdrdwt_pkg::PROD_W;
  localparam int AW = $clog2(MAX_LENGTH);
  localparam logic [LW-1:0] LEN_CAP =
    LW'((MAX_LENGTH > (1 << LW) - 1) ? (1 << LW) - 1 : MAX_LENGTH);
  localparam logic [VW-1:0] LEV_CAP =
    VW'((MAX_LEVELS > (1 << VW) - 1) ? (1 << VW) - 1 : MAX_LEVELS);
  localparam logic signed [PW:0] SAT_HI = (PW+1)'((1 << (OW - 1)) - 1);
  localparam logic signed [PW:0] SAT_LO = -(PW+1)'(1 << (OW - 1));
  localparam logic signed [PW:0] RND    = (PW+1)'(1 << (fdrdwt_pkg::FRAC_W - 1));

  // configuration
  logic [LW-1:0] len_reg;
  logic [VW-1:0] lev_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LW'(1024);
      lev_reg <= VW'(1);
    end else if (cfg_write_en) begin
      case (cfg_index)
        fdrdwt_pkg::REG_SIGNAL_LENGTH: len_reg <= cfg_data;
        fdrdwt_pkg::REG_LEVELS:        lev_reg <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // filter memory
  fdrdwt_pkg::filt_t mem [MAX_LENGTH];
  fdrdwt_pkg::filt_t frd;
  fdrdwt_pkg::filt_t fwr;
  logic [31:0] wbin32, rbin32;
  logic        w_in_range;
  logic [LW-1:0] rem_reg;

  assign wbin32     = 32'(in_data.bin_index);
  assign rbin32     = 32'(rem_reg);
  assign w_in_range = wbin32 < 32'(MAX_LENGTH);
  assign fwr = '{low_re: in_data.first_real, low_im: in_data.first_imag,
                 high_re: in_data.second_real, high_im: in_data.second_imag};

  always_ff @(posedge clk) begin
    if (cmd.mem_write && w_in_range) mem[wbin32[AW-1:0]] <= fwr;
    if (cmd.mem_read) frd <= mem[rbin32[AW-1:0]];
  end

  // item registers
  logic [fdrdwt_pkg::BIN_W-1:0] k_reg, k_sh;
  logic [LW-1:0] n_reg;
  logic [VW-1:0] nlev_reg, lvl;
  logic signed [OW-1:0] a_re, a_im, n_re, n_im, d_re, d_im;
  logic [LW-1:0] n_clamp;
  logic [VW-1:0] nlev_clamp;

  assign n_clamp = (len_reg < LW'(2)) ? LW'(2) :
                   ((len_reg > LEN_CAP) ? LEN_CAP : len_reg);
  assign nlev_clamp = (lev_reg == '0) ? VW'(1) :
                      ((lev_reg > LEV_CAP) ? LEV_CAP : lev_reg);

  // remainder step: shift in a bin bit (reduction) or a zero (doubling)
  logic [LW:0] rem_sh;
  logic [LW:0] rem_sub;
  logic [LW-1:0] rem_new;

  assign rem_sh  = {rem_reg, cmd.mod_step ? k_sh[fdrdwt_pkg::BIN_W-1] : 1'b0};
  assign rem_sub = rem_sh - {1'b0, n_reg};
  assign rem_new = (rem_sh >= {1'b0, n_reg}) ? rem_sub[LW-1:0] : rem_sh[LW-1:0];

  // shared multiplier operands
  logic signed [SW-1:0] f_r, f_i, fop;
  logic signed [OW-1:0] vop;
  logic signed [PW-1:0] prod, acc;
  logic signed [PW:0]   sum, rnd;
  logic signed [OW-1:0] sat;

  assign f_r = cmd.mul_term[2] ? frd.low_re : frd.high_re;
  assign f_i = cmd.mul_term[2] ? frd.low_im : frd.high_im;
  assign fop = cmd.mul_term[0] ? f_i : f_r;
  assign vop = (cmd.mul_term[1] ^ cmd.mul_term[0]) ? a_im : a_re;

  // real parts subtract the imag*imag term
  assign sum = cmd.acc_term[1] ? ((PW+1)'(acc) + (PW+1)'(prod))
                               : ((PW+1)'(acc) - (PW+1)'(prod));
  assign rnd = (sum + RND) >>> fdrdwt_pkg::FRAC_W;
  assign sat = (rnd > SAT_HI) ? SAT_HI[OW-1:0] :
               ((rnd < SAT_LO) ? SAT_LO[OW-1:0] : rnd[OW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      k_reg    <= in_data.bin_index;
      k_sh     <= in_data.bin_index;
      rem_reg  <= '0;
      n_reg    <= n_clamp;
      nlev_reg <= nlev_clamp;
      lvl      <= '0;
      a_re     <= OW'(in_data.first_real);
      a_im     <= OW'(in_data.first_imag);
    end
    if (cmd.mod_step) begin
      rem_reg <= rem_new;
      k_sh    <= {k_sh[fdrdwt_pkg::BIN_W-2:0], 1'b0};
    end
    if (cmd.mul_en) prod <= fop * vop;
    if (cmd.acc_en) begin
      if (!cmd.acc_term[0]) begin
        acc <= prod;
      end else begin
        case (cmd.acc_term[2:1])
          2'd0:    d_re <= sat;
          2'd1:    d_im <= sat;
          2'd2:    n_re <= sat;
          default: n_im <= sat;
        endcase
      end
    end
    if (cmd.emit_detail) begin
      a_re    <= n_re;
      a_im    <= n_im;
      lvl     <= lvl + 1'b1;
      rem_reg <= rem_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_detail || cmd.emit_approx) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_detail) begin
      out_data <= '{kind: fdrdwt_pkg::KIND_DETAIL,
                    level_number: lvl[fdrdwt_pkg::LVL_OUT_W-1:0],
                    out_index: k_reg, out_real: d_re, out_imag: d_im, last: 1'b0};
    end else if (cmd.emit_approx) begin
      out_data <= '{kind: fdrdwt_pkg::KIND_APPROX, level_number: '0,
                    out_index: k_reg, out_real: a_re, out_imag: a_im, last: 1'b1};
    end
  end

  assign status.sample_item = (in_data.mode == fdrdwt_pkg::MODE_SAMPLE);
  assign status.last_level  = (lvl == nlev_reg - 1'b1);
  assign status.out_free    = !out_valid || out_ready;

endmodule

FILE: hdl/frequency_domain_redundant_dwt.sv
// Top level of the frequency-domain redundant wavelet analysis block.
// Instantiates fdrdwt_ctrl and fdrdwt_dp; depends on fdrdwt_pkg.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  input   | in_valid, in_ready, in_data           | in
//  result  | out_valid, out_ready, out_data        | out
//  config  | cfg_write_en, cfg_index, cfg_data     | in
//
// A load item is written to the filter table from the idle state. A sample item
// runs a bit-serial bin reduction, then per level a table read, nine steps
// through the one shared 16x24 multiplier and a detail emit, then an approx emit.
// One item is worked on at a time; the next is taken once the approximation
// sits in the output register. A stalled output holds the emit step.
// Reset idles control, sets config to 1024 and 1; filter table is not cleared.
module frequency_domain_redundant_dwt #(
  parameter int MAX_LENGTH = 1024,
  parameter int MAX_LEVELS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fdrdwt_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fdrdwt_pkg::out_item_t             out_data,
  input  logic                              cfg_write_en,
  input  logic [fdrdwt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fdrdwt_pkg::LEN_W-1:0]      cfg_data
);

  fdrdwt_pkg::ctrl_cmd_t    cmd;
  fdrdwt_pkg::ctrl_status_t status;

  fdrdwt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fdrdwt_dp #(
    .MAX_LENGTH (MAX_LENGTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data      (in_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

FILE: hdl/fdrdwt_checker.sv
// Port-level checks for frequency_domain_redundant_dwt, bound to the top level.
// Depends on fdrdwt_pkg.
module fdrdwt_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input fdrdwt_pkg::in_item_t             in_data,
  input logic                             out_valid,
  input logic                             out_ready,
  input fdrdwt_pkg::out_item_t            out_data
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last == out_data.kind))
    else $error("last flag does not match approximation kind");

  a_approx_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == fdrdwt_pkg::KIND_APPROX |-> out_data.level_number == '0)
    else $error("approximation carries a nonzero level");

  // a sample item keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.mode == fdrdwt_pkg::MODE_SAMPLE |=> !in_ready)
    else $error("item accepted during a sample run");

endmodule

bind frequency_domain_redundant_dwt fdrdwt_checker u_fdrdwt_checker (.*);

FILE: bench/frequency_domain_redundant_dwt_tb.sv
// Self-checking bench for frequency_domain_redundant_dwt: loads filter bins, sends
// spectrum bins and checks every detail and approximation item against its own model.
// Depends on fdrdwt_pkg and the RTL of the block.
module frequency_domain_redundant_dwt_tb;

  localparam int TABLE_DEPTH = 1024;
  localparam int LEVEL_CAP = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 128;
  localparam int HOLDOFF_CYCLES = 400;
  localparam longint ROUND_HALF = longint'(1) << (fdrdwt_pkg::FRAC_W - 1);
  localparam longint SAT_HI = (longint'(1) << (fdrdwt_pkg::OUT_W - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  fdrdwt_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  fdrdwt_pkg::out_item_t out_data;
  logic cfg_write_en;
  logic [fdrdwt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fdrdwt_pkg::LEN_W-1:0] cfg_data;

  fdrdwt_pkg::filt_t filter_bank [TABLE_DEPTH];
  bit bank_written [TABLE_DEPTH];
  logic [fdrdwt_pkg::LEN_W-1:0] length_reg = fdrdwt_pkg::LEN_W'(TABLE_DEPTH);
  logic [fdrdwt_pkg::LEV_W-1:0] levels_reg = fdrdwt_pkg::LEV_W'(1);
  fdrdwt_pkg::out_item_t pending_coeffs[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned holdoff_requests = 0;
  int unsigned holdoffs_served = 0;
  int unsigned holdoff_left = 0;
  int unsigned items_sent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  frequency_domain_redundant_dwt #(
    .MAX_LENGTH(TABLE_DEPTH),
    .MAX_LEVELS(LEVEL_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned active_length();
    if (length_reg < 2) return 2;
    if (length_reg > TABLE_DEPTH) return TABLE_DEPTH;
    return length_reg;
  endfunction

  function automatic int unsigned active_levels();
    if (levels_reg < 1) return 1;
    if (levels_reg > LEVEL_CAP) return LEVEL_CAP;
    return levels_reg;
  endfunction

  // divide by 2^14, ties toward plus infinity, clamp to 24 bits
  function automatic longint round_saturate(longint acc);
    longint q;
    q = (acc + ROUND_HALF) >>> fdrdwt_pkg::FRAC_W;
    if (q > SAT_HI) q = SAT_HI;
    else if (q < SAT_LO) q = SAT_LO;
    return q;
  endfunction

  function automatic logic signed [fdrdwt_pkg::SMP_W-1:0] random_tap();
    if ($urandom_range(2) == 0) return fdrdwt_pkg::SMP_W'($urandom);
    return fdrdwt_pkg::SMP_W'($urandom_range(24000) - 12000);
  endfunction

  task automatic compute_coefficients(input fdrdwt_pkg::in_item_t item);
    int unsigned span;
    int unsigned depth;
    int unsigned bin;
    int unsigned lvl;
    longint ar, ai, lr, li, hr, hi, dr, di, nr;
    fdrdwt_pkg::out_item_t coeff;
    if (item.mode == fdrdwt_pkg::MODE_LOAD) begin
      filter_bank[item.bin_index] = {item.first_real, item.first_imag,
                                     item.second_real, item.second_imag};
      bank_written[item.bin_index] = 1'b1;
      return;
    end
    span = active_length();
    depth = active_levels();
    bin = item.bin_index % span;
    ar = $signed(item.first_real);
    ai = $signed(item.first_imag);
    coeff.out_index = item.bin_index;
    for (lvl = 0; lvl < depth; lvl++) begin
      lr = $signed(filter_bank[bin].low_re);
      li = $signed(filter_bank[bin].low_im);
      hr = $signed(filter_bank[bin].high_re);
      hi = $signed(filter_bank[bin].high_im);
      dr = round_saturate(hr * ar - hi * ai);
      di = round_saturate(hr * ai + hi * ar);
      nr = round_saturate(lr * ar - li * ai);
      ai = round_saturate(lr * ai + li * ar);
      ar = nr;
      coeff.kind = fdrdwt_pkg::KIND_DETAIL;
      coeff.level_number = fdrdwt_pkg::LVL_OUT_W'(lvl);
      coeff.out_real = fdrdwt_pkg::OUT_W'(dr);
      coeff.out_imag = fdrdwt_pkg::OUT_W'(di);
      coeff.last = 1'b0;
      pending_coeffs.push_back(coeff);
      bin = (bin * 2) % span;
    end
    coeff.kind = fdrdwt_pkg::KIND_APPROX;
    coeff.level_number = '0;
    coeff.out_real = fdrdwt_pkg::OUT_W'(ar);
    coeff.out_imag = fdrdwt_pkg::OUT_W'(ai);
    coeff.last = 1'b1;
    pending_coeffs.push_back(coeff);
  endtask

  // valid stays up across back-to-back items; it only drops on an idle cycle
  task automatic send_item(input fdrdwt_pkg::in_item_t item);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    compute_coefficients(item);
  endtask

  task automatic load_bin(input logic [fdrdwt_pkg::BIN_W-1:0] k,
                          input logic signed [fdrdwt_pkg::SMP_W-1:0] lr,
                          input logic signed [fdrdwt_pkg::SMP_W-1:0] li,
                          input logic signed [fdrdwt_pkg::SMP_W-1:0] hr,
                          input logic signed [fdrdwt_pkg::SMP_W-1:0] hi);
    fdrdwt_pkg::in_item_t item;
    item.mode = fdrdwt_pkg::MODE_LOAD;
    item.bin_index = k;
    item.first_real = lr;
    item.first_imag = li;
    item.second_real = hr;
    item.second_imag = hi;
    send_item(item);
  endtask

  // fills any filter bin this sample will read that was never written
  task automatic sample_bin(input logic [fdrdwt_pkg::BIN_W-1:0] k,
                            input logic signed [fdrdwt_pkg::SMP_W-1:0] re,
                            input logic signed [fdrdwt_pkg::SMP_W-1:0] im);
    int unsigned span;
    int unsigned bin;
    fdrdwt_pkg::in_item_t item;
    span = active_length();
    bin = k % span;
    repeat (active_levels()) begin
      if (!bank_written[bin])
        load_bin(fdrdwt_pkg::BIN_W'(bin), random_tap(), random_tap(), random_tap(),
                 random_tap());
      bin = (bin * 2) % span;
    end
    item.mode = fdrdwt_pkg::MODE_SAMPLE;
    item.bin_index = k;
    item.first_real = re;
    item.first_imag = im;
    item.second_real = fdrdwt_pkg::SMP_W'($urandom);
    item.second_imag = fdrdwt_pkg::SMP_W'($urandom);
    send_item(item);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_coeffs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [fdrdwt_pkg::LEN_W-1:0] length_val,
                           input logic [fdrdwt_pkg::LEV_W-1:0] levels_val);
    cfg_write_en <= 1'b1;
    cfg_index <= fdrdwt_pkg::REG_SIGNAL_LENGTH;
    cfg_data <= length_val;
    @(posedge clk);
    cfg_index <= fdrdwt_pkg::REG_LEVELS;
    cfg_data <= fdrdwt_pkg::LEN_W'(levels_val);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    length_reg = length_val;
    levels_reg = levels_val;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    fdrdwt_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_coeffs.size() == 0) begin
        $error("unexpected result item for bin %0d", out_data.out_index);
        error_count++;
      end else begin
        want = pending_coeffs.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("level_number", want.level_number, out_data.level_number);
        check_field("out_index", want.out_index, out_data.out_index);
        check_field("out_real", $signed(want.out_real), $signed(out_data.out_real));
        check_field("out_imag", $signed(want.out_imag), $signed(out_data.out_imag));
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // receiver ready; long holdoffs are counted down here
  always @(posedge clk) begin : result_ready
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holdoffs_served != holdoff_requests) begin
      holdoffs_served <= holdoffs_served + 1;
      holdoff_left <= HOLDOFF_CYCLES;
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic run_traffic(input int unsigned count);
    int unsigned stop_at;
    logic [fdrdwt_pkg::BIN_W-1:0] k;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        load_bin(fdrdwt_pkg::BIN_W'($urandom), random_tap(), random_tap(), random_tap(),
                 random_tap());
      end else begin
        if ($urandom_range(9) < 7) k = fdrdwt_pkg::BIN_W'($urandom);
        else k = fdrdwt_pkg::BIN_W'($urandom_range(active_length() - 1));
        sample_bin(k, fdrdwt_pkg::SMP_W'($urandom), fdrdwt_pkg::SMP_W'($urandom));
      end
    end
  endtask

  task automatic random_setting();
    wait_idle();
    if ($urandom_range(3) == 0)
      configure(fdrdwt_pkg::LEN_W'($urandom), fdrdwt_pkg::LEV_W'($urandom));
    else
      configure(fdrdwt_pkg::LEN_W'(1 << $urandom_range(1, 10)),
                fdrdwt_pkg::LEV_W'($urandom_range(1, LEVEL_CAP)));
  endtask

  // reset settings: N = 1024, one level
  task automatic test_reset_defaults();
    load_bin(0, 16384, 0, 0, 16384);
    sample_bin(0, 32767, -32768);
    load_bin(1023, -32768, -32768, -32768, -32768);
    sample_bin(1023, -32768, -32768);
    load_bin(512, 32767, 32767, 32767, 32767);
    sample_bin(512, 32767, 32767);
  endtask

  task automatic test_rounding_ties();
    load_bin(5, 1, 0, 1, 0);
    sample_bin(5, 8192, -8192);
    sample_bin(5, -8193, 8191);
  endtask

  // large taps over eight levels drive the approximation into the clamp
  task automatic test_saturation();
    wait_idle();
    configure(2, 8);
    load_bin(0, -32768, -32768, 32767, -32768);
    load_bin(1, 32767, -32768, -32768, 32767);
    sample_bin(1, 32767, 32767);
    sample_bin(1023, -32768, 12345);  // bin far beyond N
  endtask

  task automatic test_odd_length();
    wait_idle();
    configure(3, 4);
    load_bin(0, 12000, -3000, -9000, 4000);
    load_bin(1, -16384, 8000, 5000, -16384);
    load_bin(2, 7000, 7000, -7000, 11000);
    sample_bin(1000, -20000, 31000);
  endtask

  task automatic test_register_limits();
    wait_idle();
    configure(0, 0);
    sample_bin(3, 1234, -4321);
    wait_idle();
    configure(1, 9);
    sample_bin(0, -32768, 32767);
    wait_idle();
    configure(2047, 15);
    sample_bin(0, 32767, -1);
    wait_idle();
    configure(1025, 8);
    sample_bin(512, -1, 32767);
  endtask

  task automatic test_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                              input logic [fdrdwt_pkg::LEN_W-1:0] length_val,
                              input logic [fdrdwt_pkg::LEV_W-1:0] levels_val);
    wait_idle();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    configure(length_val, levels_val);
    run_traffic(37);
    repeat (2) begin
      random_setting();
      run_traffic(37);
    end
  endtask

  // receiver holds off while samples keep coming, so the input side stalls
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(16, 8);
    holdoff_requests <= holdoff_requests + 1;
    run_traffic(20);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write_en <= 1'b0;
    cfg_index <= fdrdwt_pkg::REG_SIGNAL_LENGTH;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_rounding_ties();
    test_saturation();
    test_odd_length();
    test_register_limits();
    test_traffic(0, 0, 1024, 8);
    test_traffic(48, 0, 2, 1);
    test_traffic(0, 48, 64, 6);
    test_traffic(27, 27, 1024, 1);
    test_backpressure();

    wait_idle();
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
